// ===== design/dtc_pkg.sv =====
`timescale 1ns / 1ps

package dtc_pkg;

    // Table geometry.
    localparam int ENTRIES = 16;
    localparam int SLOT_W  = $clog2(ENTRIES);

    // Operation codes.
    localparam logic [2:0] OP_PASS     = 3'd0;
    localparam logic [2:0] OP_FAIL     = 3'd1;
    localparam logic [2:0] OP_NEWCYCLE = 3'd2;
    localparam logic [2:0] OP_CLRALL   = 3'd3;
    localparam logic [2:0] OP_CLRONE   = 3'd4;
    localparam logic [2:0] OP_QUERY    = 3'd5;
    localparam logic [2:0] OP_GET      = 3'd6;

    // Result kinds.
    localparam logic [2:0] KIND_FIRST    = 3'd0;
    localparam logic [2:0] KIND_LATEST   = 3'd1;
    localparam logic [2:0] KIND_NOTFOUND = 3'd2;
    localparam logic [2:0] KIND_FULL     = 3'd3;
    localparam logic [2:0] KIND_EMPTY    = 3'd4;

    // Configuration register indexes.
    localparam logic [0:0] CFG_CONFIRM = 1'd0;
    localparam logic [0:0] CFG_AGING   = 1'd1;

    // Status byte bits.
    localparam logic [7:0] ST_TF    = 8'h01;
    localparam logic [7:0] ST_TFTOC = 8'h02;
    localparam logic [7:0] ST_PEND  = 8'h04;
    localparam logic [7:0] ST_CONF  = 8'h08;
    localparam logic [7:0] ST_TNC   = 8'h10;
    localparam logic [7:0] ST_TFSLC = 8'h20;
    localparam logic [7:0] ST_TNCTOC= 8'h40;
    localparam logic [7:0] ST_WIR   = 8'h80;
    localparam logic [7:0] ST_NEW   = 8'h50;
    localparam logic [7:0] CNT_MAX  = 8'hFF;

    typedef struct packed {
        logic [63:0] time_ms;
        logic [15:0] speed;
        logic [15:0] rpm;
        logic [15:0] voltage;
        logic [15:0] temp;
        logic [31:0] odometer;
    } t_frame;

    typedef struct packed {
        logic        valid;
        logic [23:0] code;
        logic [7:0]  status;
        logic [7:0]  occ;
        logic [7:0]  aging;
        t_frame      first;
        t_frame      latest;
    } t_rec;

    // Command broadcast to every cell for one cycle.
    typedef struct packed {
        logic        en;
        logic [2:0]  op;
        logic [23:0] code;
        logic [7:0]  mask;
        logic [7:0]  confirm;
        logic [7:0]  aging;
        t_frame      frame;
        logic [SLOT_W-1:0] alloc;
        logic        do_alloc;
    } t_cmd;

    // Per-cell result handed to the controller.
    typedef struct packed {
        logic        hit;
        logic        match;
        logic        free;
    } t_flags;

endpackage

// ===== design/dtc_cell.sv =====
`timescale 1ns / 1ps

module dtc_cell
    import dtc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  t_cmd   i_cmd,
    input  logic   i_shift,
    input  t_rec   i_prev,
    output t_rec   o_rec,
    output t_flags o_flags
);

    t_rec r_rec;
    t_rec n_rec;
    logic [7:0] w_occ;
    logic [7:0] w_age;
    logic [7:0] w_st;

    assign o_rec = r_rec;
    assign o_flags.hit   = r_rec.valid && (r_rec.code == i_cmd.code);
    assign o_flags.match = r_rec.valid && ((r_rec.status & i_cmd.mask) != 8'd0);
    assign o_flags.free  = !r_rec.valid;

    // Shift, report and maintenance update of this record.
    always_comb begin
        n_rec = r_rec;
        w_occ = 8'd0;
        w_age = 8'd0;
        w_st  = 8'd0;
        if (i_shift) begin
            n_rec = i_prev;
        end else if (i_cmd.en) begin
            case (i_cmd.op)
                OP_PASS, OP_FAIL: begin
                    if (o_flags.hit || (i_cmd.do_alloc && i_cmd.alloc == i_idx)) begin
                        if (!o_flags.hit) begin
                            n_rec = '0;
                            n_rec.valid  = 1'b1;
                            n_rec.code   = i_cmd.code;
                            n_rec.status = ST_NEW;
                        end
                        w_st  = n_rec.status & ~ST_NEW;
                        w_occ = n_rec.occ;
                        w_age = n_rec.aging;
                        if (i_cmd.op == OP_FAIL) begin
                            w_st = w_st | ST_TF | ST_TFTOC | ST_TFSLC | ST_PEND;
                            w_age = 8'd0;
                            if (w_occ != CNT_MAX) begin
                                w_occ = w_occ + 8'd1;
                            end
                            if (w_occ == 8'd1) begin
                                n_rec.first = i_cmd.frame;
                            end
                            n_rec.latest = i_cmd.frame;
                            if (w_occ >= i_cmd.confirm) begin
                                w_st = w_st | ST_CONF | ST_WIR;
                            end
                        end else begin
                            w_st = w_st & ~ST_TF;
                            if ((w_st & (ST_CONF | ST_PEND)) != 8'd0) begin
                                if (w_age != CNT_MAX) begin
                                    w_age = w_age + 8'd1;
                                end
                                if (w_age >= i_cmd.aging) begin
                                    w_st = w_st & ~(ST_PEND | ST_CONF | ST_WIR);
                                end
                            end
                        end
                        n_rec.status = w_st;
                        n_rec.occ    = w_occ;
                        n_rec.aging  = w_age;
                    end
                end
                OP_NEWCYCLE: begin
                    if (r_rec.valid) begin
                        n_rec.status = (r_rec.status & ~ST_TFTOC) | ST_TNCTOC;
                    end
                end
                OP_CLRALL: begin
                    n_rec.valid = 1'b0;
                end
                OP_CLRONE: begin
                    if (o_flags.hit) begin
                        n_rec.valid = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        // Reset only empties the slot; the payload is left as it is.
        if (!i_rst_n) begin
            n_rec.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// ===== design/dtc_fault_memory.sv =====
`timescale 1ns / 1ps
// A get is executed against the table and then emits its words; a query first runs a scan pass.
// A query rotates the cell chain through one full turn of the ring per listed record and then
// emits two words for that record.
// Throughput: one item at a time; the next item is taken only once the previous one has
// finished and its last word, if any, has been accepted at the output.
// Reset: synchronous, active low; the table is empty and thresholds return to 3 and 40.
module dtc_fault_memory
    import dtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [23:0] i_dtc_code,
    input  logic [7:0]  i_status_mask,
    input  logic [63:0] i_snap_time_ms,
    input  logic [15:0] i_snap_speed,
    input  logic [15:0] i_snap_rpm,
    input  logic [15:0] i_snap_voltage,
    input  logic signed [15:0] i_snap_temp,
    input  logic [31:0] i_snap_odometer,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_out_code,
    output logic [7:0]  o_out_status,
    output logic [7:0]  o_out_occurrences,
    output logic [7:0]  o_out_aging,
    output logic [2:0]  o_result_kind,
    output logic [63:0] o_frame_time_ms,
    output logic [15:0] o_frame_speed,
    output logic [15:0] o_frame_rpm,
    output logic [15:0] o_frame_voltage,
    output logic signed [15:0] o_frame_temp,
    output logic [31:0] o_frame_odometer,
    output logic        o_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EMIT1 = 3'd3;
    localparam logic [2:0] S_EMIT2 = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;

    logic [2:0]  r_state;
    logic [7:0]  r_confirm;
    logic [7:0]  r_aging;
    logic [2:0]  r_op;
    logic [23:0] r_code;
    logic [7:0]  r_mask;
    t_frame      r_frame;
    logic [SLOT_W-1:0] r_scan;
    logic        r_found;
    logic        r_more;
    logic        r_have_prev;
    logic [23:0] r_prev;
    t_rec        r_best;
    logic        r_emit;
    logic        r_ov;

    t_rec   w_rec   [ENTRIES];
    t_flags w_flags [ENTRIES];
    t_rec   w_ring  [ENTRIES];
    t_cmd   w_cmd;
    logic   w_shift;
    logic   w_hit;
    logic [SLOT_W-1:0] w_hit_idx;
    logic   w_free;
    logic [SLOT_W-1:0] w_free_idx;
    logic   w_qual;
    logic   w_cand;
    logic   w_out_free;
    logic   w_load;
    logic   w_quiet;
    logic   w_empty;
    t_frame w_frame;

    // The records form a ring: each cell hands its record to the next while scanning.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign w_ring[g] = w_rec[(g + ENTRIES - 1) % ENTRIES];
        dtc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_cmd   (w_cmd),
            .i_shift (w_shift),
            .i_prev  (w_ring[g]),
            .o_rec   (w_rec[g]),
            .o_flags (w_flags[g])
        );
    end

    // Hit and lowest free slot over the row.
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (w_flags[k].hit) begin
                w_hit     = 1'b1;
                w_hit_idx = SLOT_W'(k);
            end
            if (w_flags[k].free) begin
                w_free     = 1'b1;
                w_free_idx = SLOT_W'(k);
            end
        end
    end

    assign w_out_free = !o_valid || i_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_valid;
    assign w_shift     = (r_state == S_SCAN);

    assign w_cmd.en       = (r_state == S_EXEC);
    assign w_cmd.op       = r_op;
    assign w_cmd.code     = r_code;
    assign w_cmd.mask     = r_mask;
    assign w_cmd.confirm  = r_confirm;
    assign w_cmd.aging    = r_aging;
    assign w_cmd.frame    = r_frame;
    assign w_cmd.alloc    = w_free_idx;
    assign w_cmd.do_alloc = !w_hit && w_free;

    // The record at the ring head qualifies when it matches and lies above the last code;
    // it becomes the candidate when it is also below the best one seen in this pass.
    assign w_qual = w_flags[0].match && (!r_have_prev || (w_rec[0].code > r_prev));
    assign w_cand = w_qual && (!r_found || (w_rec[0].code < r_best.code));

    // Controller.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_confirm <= 8'd3;
            r_aging   <= 8'd40;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        if (i_cfg_index == CFG_CONFIRM) begin
                            r_confirm <= i_cfg_data;
                        end else begin
                            r_aging <= i_cfg_data;
                        end
                    end
                    if (i_valid) begin
                        r_op   <= i_operation;
                        r_code <= i_dtc_code;
                        r_mask <= i_status_mask;
                        r_frame <= '{i_snap_time_ms, i_snap_speed, i_snap_rpm,
                                     i_snap_voltage, i_snap_temp, i_snap_odometer};
                        r_have_prev <= 1'b0;
                        r_found <= 1'b0;
                        r_more  <= 1'b0;
                        r_scan  <= '0;
                        r_state <= (i_operation == OP_QUERY) ? S_SCAN : S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_GET) begin
                        r_emit  <= 1'b1;
                        r_found <= w_hit;
                        r_best  <= w_rec[w_hit_idx];
                        r_state <= w_hit ? S_EMIT1 : S_WAIT;
                    end else begin
                        r_emit  <= (r_op == OP_PASS || r_op == OP_FAIL) && !w_hit && !w_free;
                        r_state <= S_WAIT;
                    end
                end
                S_SCAN: begin
                    if (w_cand) begin
                        r_found <= 1'b1;
                        r_best  <= w_rec[0];
                    end
                    // A second qualifying record means this pass does not list the last one.
                    if (w_qual && r_found) begin
                        r_more <= 1'b1;
                    end
                    r_scan <= r_scan + SLOT_W'(1);
                    if (r_scan == SLOT_W'(ENTRIES - 1)) begin
                        r_state <= S_EMIT1;
                        r_emit  <= 1'b1;
                    end
                end
                S_EMIT1: begin
                    if (w_out_free) begin
                        if (r_found) begin
                            r_state <= S_EMIT2;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_EMIT2: begin
                    if (w_out_free) begin
                        if (r_op == OP_QUERY && r_more) begin
                            r_have_prev <= 1'b1;
                            r_prev  <= r_best.code;
                            r_found <= 1'b0;
                            r_more  <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output word register: load in the execute and emit states, hold while stalled.
    assign w_quiet = (r_state == S_EXEC) && !(r_op == OP_GET)
                     && !((r_op == OP_PASS || r_op == OP_FAIL) && !w_hit && !w_free);
    assign w_load = w_out_free && ((r_state == S_EMIT1 && r_emit) || r_state == S_EMIT2
                    || (r_state == S_EXEC && !w_quiet && !(r_op == OP_GET && w_hit)));
    assign w_empty = (r_state == S_EMIT1) && !r_found;
    assign w_frame = (r_state == S_EMIT1) ? r_best.first : r_best.latest;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_free) begin
            r_ov <= w_load;
        end
        if (w_load) begin
            if (r_state == S_EXEC || w_empty) begin
                // Single-word answers: not found, table full or an empty query.
                o_out_code        <= w_empty ? 24'd0 : r_code;
                o_out_status      <= 8'd0;
                o_out_occurrences <= 8'd0;
                o_out_aging       <= 8'd0;
                o_result_kind     <= w_empty ? KIND_EMPTY
                                     : ((r_op == OP_GET) ? KIND_NOTFOUND : KIND_FULL);
                o_frame_time_ms   <= 64'd0;
                o_frame_speed     <= 16'd0;
                o_frame_rpm       <= 16'd0;
                o_frame_voltage   <= 16'd0;
                o_frame_temp      <= 16'sd0;
                o_frame_odometer  <= 32'd0;
                o_last            <= 1'b1;
            end else begin
                o_out_code        <= r_best.code;
                o_out_status      <= r_best.status;
                o_out_occurrences <= r_best.occ;
                o_out_aging       <= r_best.aging;
                o_result_kind     <= (r_state == S_EMIT1) ? KIND_FIRST : KIND_LATEST;
                o_frame_time_ms   <= w_frame.time_ms;
                o_frame_speed     <= w_frame.speed;
                o_frame_rpm       <= w_frame.rpm;
                o_frame_voltage   <= w_frame.voltage;
                o_frame_temp      <= w_frame.temp;
                o_frame_odometer  <= w_frame.odometer;
                o_last            <= (r_state == S_EMIT2) && !(r_op == OP_QUERY && r_more);
            end
        end
    end

`ifndef SYNTH
    // No input is taken while a word is still being produced.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("input taken while busy");
    // A stalled output word stays valid and holds its code and result kind.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_code) && $stable(o_result_kind)))
        else $error("output word changed under stall");
    // Configuration never lands while an item is in progress.
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cfg_ready)
        else $error("configuration accepted while busy");
`endif

endmodule

// ===== verif/dtc_fault_memory_tb.sv =====
`timescale 1ns / 1ps

module dtc_fault_memory_tb;
    import dtc_pkg::*;

    typedef struct packed {
        logic [2:0]  op;
        logic [23:0] code;
        logic [7:0]  mask;
        t_frame      frame;
    } t_item;

    typedef struct packed {
        logic [23:0] code;
        logic [7:0]  status;
        logic [7:0]  occ;
        logic [7:0]  aging;
        logic [2:0]  kind;
        t_frame      frame;
        logic        last;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [23:0] i_dtc_code;
    logic [7:0]  i_status_mask;
    logic [63:0] i_snap_time_ms;
    logic [15:0] i_snap_speed;
    logic [15:0] i_snap_rpm;
    logic [15:0] i_snap_voltage;
    logic signed [15:0] i_snap_temp;
    logic [31:0] i_snap_odometer;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_valid;
    logic        i_ready;
    logic [23:0] o_out_code;
    logic [7:0]  o_out_status;
    logic [7:0]  o_out_occurrences;
    logic [7:0]  o_out_aging;
    logic [2:0]  o_result_kind;
    logic [63:0] o_frame_time_ms;
    logic [15:0] o_frame_speed;
    logic [15:0] o_frame_rpm;
    logic [15:0] o_frame_voltage;
    logic signed [15:0] o_frame_temp;
    logic [31:0] o_frame_odometer;
    logic        o_last;

    dtc_fault_memory DUT (.*);

    // Shadow copy of the fault memory.
    logic        mem_valid [ENTRIES];
    logic [23:0] mem_code  [ENTRIES];
    logic [7:0]  mem_status[ENTRIES];
    logic [7:0]  mem_occ   [ENTRIES];
    logic [7:0]  mem_aging [ENTRIES];
    t_frame      mem_first [ENTRIES];
    t_frame      mem_latest[ENTRIES];
    logic [7:0]  confirm_thr;
    logic [7:0]  aging_thr;

    t_item pending_items[$];
    t_word expected_words[$];
    int    errors;
    int    idle_cycles;
    int    hold_off;
    bit    hold_req;
    bit    hold_started;
    bit    pause_req;
    bit    cfg_busy;

    // Clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int find_code(logic [23:0] code);
        for (int i = 0; i < ENTRIES; i++)
            if (mem_valid[i] && mem_code[i] == code)
                return i;
        return -1;
    endfunction

    function automatic t_word record_word(int s, logic [2:0] kind);
        t_word w;
        w = '0;
        w.code = mem_code[s];
        w.status = mem_status[s];
        w.occ = mem_occ[s];
        w.aging = mem_aging[s];
        w.kind = kind;
        w.frame = (kind == KIND_FIRST) ? mem_first[s] : mem_latest[s];
        return w;
    endfunction

    // Update the shadow memory for one accepted item and queue its results.
    task automatic apply_item(t_item it);
        t_word res[$];
        t_word w;
        int s;
        int best;
        logic [23:0] prev;
        bit have_prev;
        case (it.op)
            OP_PASS, OP_FAIL: begin
                s = find_code(it.code);
                if (s < 0) begin
                    for (int i = 0; i < ENTRIES && s < 0; i++)
                        if (!mem_valid[i])
                            s = i;
                    if (s >= 0) begin
                        mem_valid[s] = 1'b1;
                        mem_code[s] = it.code;
                        mem_status[s] = ST_NEW;
                        mem_occ[s] = '0;
                        mem_aging[s] = '0;
                        mem_first[s] = '0;
                        mem_latest[s] = '0;
                    end
                end
                if (s < 0) begin
                    w = '0;
                    w.code = it.code;
                    w.kind = KIND_FULL;
                    res = {res, w};
                end else begin
                    mem_status[s] &= ~ST_NEW;
                    if (it.op == OP_FAIL) begin
                        mem_status[s] |= ST_TF | ST_TFTOC | ST_TFSLC | ST_PEND;
                        mem_aging[s] = '0;
                        if (mem_occ[s] != CNT_MAX)
                            mem_occ[s]++;
                        if (mem_occ[s] == 8'd1)
                            mem_first[s] = it.frame;
                        mem_latest[s] = it.frame;
                        if (mem_occ[s] >= confirm_thr)
                            mem_status[s] |= ST_CONF | ST_WIR;
                    end else begin
                        mem_status[s] &= ~ST_TF;
                        if (mem_status[s] & (ST_CONF | ST_PEND)) begin
                            if (mem_aging[s] != CNT_MAX)
                                mem_aging[s]++;
                            if (mem_aging[s] >= aging_thr)
                                mem_status[s] &= ~(ST_PEND | ST_CONF | ST_WIR);
                        end
                    end
                end
            end
            OP_NEWCYCLE: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (mem_valid[i])
                        mem_status[i] = (mem_status[i] & ~ST_TFTOC) | ST_TNCTOC;
            end
            OP_CLRALL: begin
                for (int i = 0; i < ENTRIES; i++)
                    mem_valid[i] = 1'b0;
            end
            OP_CLRONE: begin
                s = find_code(it.code);
                if (s >= 0)
                    mem_valid[s] = 1'b0;
            end
            OP_QUERY: begin
                have_prev = 1'b0;
                prev = '0;
                for (int n = 0; n < ENTRIES; n++) begin
                    best = -1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!mem_valid[i] || (mem_status[i] & it.mask) == 0)
                            continue;
                        if (have_prev && mem_code[i] <= prev)
                            continue;
                        if (best < 0 || mem_code[i] < mem_code[best])
                            best = i;
                    end
                    if (best < 0)
                        break;
                    res = {res, record_word(best, KIND_FIRST)};
                    res = {res, record_word(best, KIND_LATEST)};
                    prev = mem_code[best];
                    have_prev = 1'b1;
                end
                if (res.size() == 0) begin
                    w = '0;
                    w.kind = KIND_EMPTY;
                    res = {res, w};
                end
            end
            OP_GET: begin
                s = find_code(it.code);
                if (s >= 0) begin
                    res = {res, record_word(s, KIND_FIRST)};
                    res = {res, record_word(s, KIND_LATEST)};
                end else begin
                    w = '0;
                    w.code = it.code;
                    w.kind = KIND_NOTFOUND;
                    res = {res, w};
                end
            end
            default: ;
        endcase
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[k])
            expected_words = {expected_words, res[k]};
    endtask

    // Driver: offers pending items with random gaps; honours the pause request.
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_valid && o_ready) begin
            apply_item(pending_items.pop_front());
            i_valid <= 1'b0;
            send_gap <= $urandom_range(0, 13);
        end else if (!i_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0 && !cfg_busy
                         && !(pause_req && expected_words.size() > 0)) begin
                i_valid <= 1'b1;
                i_operation <= pending_items[0].op;
                i_dtc_code <= pending_items[0].code;
                i_status_mask <= pending_items[0].mask;
                i_snap_time_ms <= pending_items[0].frame.time_ms;
                i_snap_speed <= pending_items[0].frame.speed;
                i_snap_rpm <= pending_items[0].frame.rpm;
                i_snap_voltage <= pending_items[0].frame.voltage;
                i_snap_temp <= pending_items[0].frame.temp;
                i_snap_odometer <= pending_items[0].frame.odometer;
            end
        end
    end

    // Monitor: random back-pressure, long hold-off on request, field checks.
    int recv_gap;
    t_word got;
    t_word want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_gap <= 0;
            hold_off <= 0;
            hold_started <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_out_code, o_out_status, o_out_occurrences, o_out_aging,
                       o_result_kind, o_frame_time_ms, o_frame_speed, o_frame_rpm,
                       o_frame_voltage, o_frame_temp, o_frame_odometer, o_last};
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch code exp %h act %h, status exp %h act %h",
                                 $time, want.code, got.code, want.status, got.status);
                        $display("%0t: occ exp %h act %h, aging exp %h act %h, kind %0d/%0d",
                                 $time, want.occ, got.occ, want.aging, got.aging,
                                 want.kind, got.kind);
                        $display("%0t: frame exp %h act %h, last exp %b act %b",
                                 $time, want.frame, got.frame, want.last, got.last);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_started) begin
                hold_started <= 1'b1;
                hold_off <= 300;
                i_ready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_ready <= 1'b0;
            end else if (o_valid && i_ready) begin
                recv_gap <= $urandom_range(0, 13);
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("dtc_fault_memory regression: fail");
            $finish;
        end
    end

    function automatic t_frame rand_frame();
        t_frame f;
        f.time_ms = {$urandom(), $urandom()};
        f.speed = 16'($urandom());
        f.rpm = 16'($urandom());
        f.voltage = 16'($urandom());
        f.temp = 16'($urandom());
        f.odometer = $urandom();
        return f;
    endfunction

    task automatic add_item(logic [2:0] op, logic [23:0] code, logic [7:0] mask, t_frame f);
        t_item it;
        it.op = op;
        it.code = code;
        it.mask = mask;
        it.frame = f;
        pending_items = {pending_items, it};
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !i_valid && expected_words.size() == 0);
        repeat (400) @(posedge i_clk);
    endtask

    // Register write, only with the block idle.
    task automatic write_reg(logic idx, logic [7:0] data);
        cfg_busy = 1'b1;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CONFIRM)
            confirm_thr = data;
        else
            aging_thr = data;
        cfg_busy = 1'b0;
    endtask

    // Random phase: code pool kept small so records are reused; with a large enough pool the table can fill.
    task automatic random_phase(int count, int pool);
        logic [23:0] codes[4];
        int r;
        codes = '{24'h000000, 24'hFFFFFF, 24'h123456, 24'h800001};
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                add_item(OP_FAIL, 24'($urandom_range(0, pool)), 8'h00, rand_frame());
            else if (r < 55)
                add_item(OP_PASS, 24'($urandom_range(0, pool)), 8'h00, rand_frame());
            else if (r < 62)
                add_item(OP_NEWCYCLE, 24'($urandom()), 8'($urandom()), rand_frame());
            else if (r < 64)
                add_item(OP_CLRALL, 24'($urandom()), 8'($urandom()), rand_frame());
            else if (r < 70)
                add_item(OP_CLRONE, 24'($urandom_range(0, pool)), 8'($urandom()),
                         rand_frame());
            else if (r < 82)
                add_item(OP_QUERY, 24'($urandom()), 8'($urandom()), rand_frame());
            else if (r < 95)
                add_item(OP_GET, 24'($urandom_range(0, pool)), 8'($urandom()), rand_frame());
            else if (r < 97)
                add_item(3'd7, 24'($urandom()), 8'($urandom()), rand_frame());
            else
                add_item(OP_FAIL, codes[$urandom_range(0, 3)], 8'h00, rand_frame());
        end
    endtask

    initial begin
        t_frame ones;
        ones = '1;
        errors = 0;
        hold_req = 1'b0;
        pause_req = 1'b0;
        cfg_busy = 1'b0;
        confirm_thr = 8'd3;
        aging_thr = 8'd40;
        for (int i = 0; i < ENTRIES; i++)
            mem_valid[i] = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty query, absent get, creation, confirmation, extremes.
        add_item(OP_QUERY, '0, 8'hFF, '0);
        add_item(OP_GET, 24'hFFFFFF, '0, '0);
        add_item(OP_FAIL, 24'hFFFFFF, '0, ones);
        add_item(OP_FAIL, 24'h000000, '0, '0);
        add_item(OP_FAIL, 24'hFFFFFF, '0, rand_frame());
        add_item(OP_FAIL, 24'hFFFFFF, '0, rand_frame());
        add_item(OP_PASS, 24'h000010, '0, '0);
        add_item(OP_GET, 24'hFFFFFF, '0, '0);
        add_item(OP_NEWCYCLE, '0, '0, '0);
        add_item(OP_QUERY, '0, 8'h00, '0);
        add_item(OP_QUERY, '0, 8'hFF, '0);
        add_item(OP_CLRONE, 24'h000000, '0, '0);
        add_item(OP_CLRONE, 24'h0000AA, '0, '0);
        add_item(3'd7, 24'hFFFFFF, 8'hFF, ones);
        // Fill the table, then rejected reports.
        for (int i = 1; i <= ENTRIES; i++)
            add_item(OP_FAIL, 24'(24'h100000 + i), '0, rand_frame());
        add_item(OP_FAIL, 24'hABCDEF, '0, rand_frame());
        // Long receiver hold-off while the largest query and more words queue up.
        add_item(OP_QUERY, '0, 8'hFF, '0);
        add_item(OP_GET, 24'h100003, '0, '0);
        wait (pending_items.size() <= 2);
        hold_req = 1'b1;
        drain();
        add_item(OP_CLRALL, '0, '0, '0);
        drain();

        // Extreme thresholds: confirm and heal on every report.
        write_reg(CFG_CONFIRM, 8'd1);
        write_reg(CFG_AGING, 8'd1);
        random_phase(15, 6);
        drain();
        // Zero aging threshold compared as given.
        write_reg(CFG_CONFIRM, 8'd255);
        write_reg(CFG_AGING, 8'd0);
        add_item(OP_FAIL, 24'h000042, '0, rand_frame());
        for (int i = 0; i < 3; i++)
            add_item(OP_PASS, 24'h000042, '0, '0);
        add_item(OP_GET, 24'h000042, '0, '0);
        random_phase(15, 20);
        drain();
        // Sender pauses until every expected word has come.
        pause_req = 1'b1;
        write_reg(CFG_CONFIRM, 8'd2);
        write_reg(CFG_AGING, 8'd255);
        random_phase(20, 24);
        drain();
        pause_req = 1'b0;
        write_reg(CFG_CONFIRM, 8'd0);
        write_reg(CFG_AGING, 8'd3);
        random_phase(20, 10);
        add_item(OP_QUERY, '0, 8'hFF, '0);
        drain();

        if (errors == 0)
            $display("dtc_fault_memory regression: pass");
        else
            $display("dtc_fault_memory regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dtc_pkg.sv
design/dtc_cell.sv
design/dtc_fault_memory.sv
verif/dtc_fault_memory_tb.sv
